### sv/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants for the line segment rasterizer
// Holds the coordinate widths, the controller state type and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lsr_pkg;

  // Fixed field widths
  localparam int COORD_W     = 6;
  localparam int ERR_W       = 8;
  localparam int TILE_SPAN_D = 64;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } lsr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture clamped endpoints
    logic setup;  // order endpoints, compute extents, reset error
    logic step;   // advance to the next pixel
  } lsr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;   // current pixel is the final one of the segment
  } lsr_sts_t;

endpackage

### sv/lsr_ctrl.sv
// ----------------------------------------------------------------------------
// lsr_ctrl: sequencer for the line segment rasterizer
// Accepts a segment, passes through a setup state, then emits one pixel beat per
// cycle while the receiver takes them, and returns to idle after the last.
// ----------------------------------------------------------------------------
module lsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lsr_pkg::lsr_sts_t sts,
  output lsr_pkg::lsr_cmd_t cmd
);
  import lsr_pkg::*;

  lsr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/lsr_dpath.sv
// ----------------------------------------------------------------------------
// lsr_dpath: endpoint, extent and error registers of the rasterizer
// Clamps and orders the endpoints, keeps the current pixel and the integer
// error term, and steps the major and minor axes on command.
// ----------------------------------------------------------------------------
module lsr_dpath #(
  parameter int TILE_SPAN = lsr_pkg::TILE_SPAN_D
) (
  input  logic              clk,
  input  lsr_pkg::coord_t   in_end_a_x,
  input  lsr_pkg::coord_t   in_end_a_y,
  input  lsr_pkg::coord_t   in_end_b_x,
  input  lsr_pkg::coord_t   in_end_b_y,
  input  lsr_pkg::lsr_cmd_t cmd,
  output lsr_pkg::lsr_sts_t sts,
  output lsr_pkg::coord_t   pixel_x,
  output lsr_pkg::coord_t   pixel_y,
  output logic              last_pixel
);
  import lsr_pkg::*;

  localparam logic [COORD_W:0] SPAN     = (COORD_W+1)'(TILE_SPAN);
  localparam coord_t           SPAN_MAX = COORD_W'(TILE_SPAN - 1);

  coord_t ax_r, ay_r, bx_r, by_r;
  coord_t cur_x_r, cur_y_r;
  coord_t major_r, minor_r;
  coord_t steps_r;
  logic   desc_r, steep_r;
  logic signed [ERR_W-1:0] err_r;

  function automatic coord_t clamp(input coord_t v);
    coord_t r;
    r = v;
    if ({1'b0, v} >= SPAN) begin
      r = SPAN_MAX;
    end
    return r;
  endfunction

  // Capture clamped endpoints
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= clamp(in_end_a_x);
      ay_r <= clamp(in_end_a_y);
      bx_r <= clamp(in_end_b_x);
      by_r <= clamp(in_end_b_y);
    end
  end

  // Order endpoints and derive extents
  logic   a_first, y_dn, steep;
  coord_t sx, sy, ex, ey, dx, dy;

  always_comb begin
    a_first = (ax_r < bx_r) || ((ax_r == bx_r) && (ay_r < by_r));
    sx      = a_first ? ax_r : bx_r;
    sy      = a_first ? ay_r : by_r;
    ex      = a_first ? bx_r : ax_r;
    ey      = a_first ? by_r : ay_r;
    dx      = ex - sx;
    y_dn    = ey < sy;
    dy      = y_dn ? (sy - ey) : (ey - sy);
    steep   = !(dx > dy);
  end

  // Error update for one step
  logic signed [ERR_W:0]   err_add;
  logic signed [ERR_W+1:0] err_dbl;
  logic                    minor_move;
  logic signed [ERR_W:0]   err_next;
  coord_t                  y_adv;

  always_comb begin
    err_add    = {err_r[ERR_W-1], err_r} + $signed({3'b000, minor_r});
    err_dbl    = {err_add, 1'b0};
    minor_move = err_dbl > $signed({4'b0000, major_r});
    err_next   = minor_move ? (err_add - $signed({3'b000, major_r})) : err_add;
    y_adv      = desc_r ? (cur_y_r - 1'b1) : (cur_y_r + 1'b1);
  end

  // Hold, set up or advance the run
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cur_x_r <= sx;
      cur_y_r <= sy;
      desc_r  <= y_dn;
      steep_r <= steep;
      major_r <= steep ? dy : dx;
      minor_r <= steep ? dx : dy;
      steps_r <= steep ? dy : dx;
      err_r   <= '0;
    end else if (cmd.step) begin
      steps_r <= steps_r - 1'b1;
      err_r   <= err_next[ERR_W-1:0];
      if (steep_r) begin
        cur_y_r <= y_adv;
        if (minor_move) begin
          cur_x_r <= cur_x_r + 1'b1;
        end
      end else begin
        cur_x_r <= cur_x_r + 1'b1;
        if (minor_move) begin
          cur_y_r <= y_adv;
        end
      end
    end
  end

  assign pixel_x    = cur_x_r;
  assign pixel_y    = cur_y_r;
  assign last_pixel = (steps_r == '0);
  assign sts.last   = last_pixel;

endmodule

### sv/line_segment_rasterizer.sv
// ----------------------------------------------------------------------------
// line_segment_rasterizer: Bresenham rasterizer for segments within a tile
// Takes one segment as two endpoints and emits every pixel of it in order,
// both endpoints included, with the final pixel flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one segment per beat: two
//   endpoints, each coordinate clamped to TILE_SPAN-1.
//   Output channel (out_valid/out_ready) carries one pixel per beat;
//   out_last_pixel marks the final pixel of the segment.
//   After the segment beat is accepted, a setup state comes first, and then
//   the first pixel is offered.
//   Throughput: one pixel per cycle while the receiver is ready; a segment
//   of N pixels (1 to TILE_SPAN) passes through the accept in idle, the
//   setup state and N pixel beats. The next segment is taken in the cycle
//   after the last pixel beat; the single stepping datapath works on one
//   segment at a time.
//   in_ready is high only while no segment is in progress.
//   Reset (rst_n low, synchronous) returns the sequencer to idle; a segment
//   in progress is dropped.
//   When the receiver stalls, the current pixel holds on the outputs and the
//   run pauses until out_ready returns.
// ----------------------------------------------------------------------------
module line_segment_rasterizer #(
  parameter int TILE_SPAN = lsr_pkg::TILE_SPAN_D
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lsr_pkg::coord_t in_end_a_x,
  input  lsr_pkg::coord_t in_end_a_y,
  input  lsr_pkg::coord_t in_end_b_x,
  input  lsr_pkg::coord_t in_end_b_y,
  output logic            out_valid,
  input  logic            out_ready,
  output lsr_pkg::coord_t out_pixel_x,
  output lsr_pkg::coord_t out_pixel_y,
  output logic            out_last_pixel
);
  import lsr_pkg::*;

  lsr_cmd_t cmd;
  lsr_sts_t sts;

  // Sequencer
  lsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Coordinate and error datapath
  lsr_dpath #(
    .TILE_SPAN (TILE_SPAN)
  ) u_dpath (
    .clk        (clk),
    .in_end_a_x (in_end_a_x),
    .in_end_a_y (in_end_a_y),
    .in_end_b_x (in_end_b_x),
    .in_end_b_y (in_end_b_y),
    .cmd        (cmd),
    .sts        (sts),
    .pixel_x    (out_pixel_x),
    .pixel_y    (out_pixel_y),
    .last_pixel (out_last_pixel)
  );

endmodule

### tb/line_segment_rasterizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_segment_rasterizer_tb: self-checking bench for the segment rasterizer
// Feeds segments on the input channel: a directed table of endpoint
// extremes and line shapes first, then random segments of mixed shapes.
// A local Bresenham predictor turns every accepted segment into its
// expected pixel beats, and each pixel beat that leaves the block is
// compared field by field with the oldest of them. Both sides idle in
// random bursts; one long receiver stall backs the block up, one drain
// pause empties it, and the last stretch runs at full rate.
// ----------------------------------------------------------------------------
module line_segment_rasterizer_tb;
  import lsr_pkg::*;

  localparam int TILE        = TILE_SPAN_D;
  localparam int LIMIT       = 2_000_000;
  localparam int N_DIRECTED  = 22;
  localparam int N_PHASE_A   = 200;
  localparam int N_BACKUP    = 6;
  localparam int N_PHASE_B   = 170;
  localparam int N_FULL_RATE = 85;
  localparam int LONG_STALL  = 400;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Directed row: typed rows are single points whose one pixel is given here
  typedef struct packed {
    logic   typed;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t px;
    coord_t py;
  } seg_row_t;

  localparam seg_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{1'b1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0 },  // single point, origin
    '{1'b1, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63},  // single point, far corner
    '{1'b1, 6'd63, 6'd0,  6'd63, 6'd0,  6'd63, 6'd0 },
    '{1'b1, 6'd0,  6'd63, 6'd0,  6'd63, 6'd0,  6'd63},
    '{1'b1, 6'd42, 6'd21, 6'd42, 6'd21, 6'd42, 6'd21},
    '{1'b0, 6'd0,  6'd0,  6'd63, 6'd0,  6'd0,  6'd0 },  // full-width horizontal
    '{1'b0, 6'd63, 6'd17, 6'd0,  6'd17, 6'd0,  6'd0 },  // horizontal, swapped ends
    '{1'b0, 6'd9,  6'd0,  6'd9,  6'd63, 6'd0,  6'd0 },  // full-height vertical
    '{1'b0, 6'd40, 6'd63, 6'd40, 6'd0,  6'd0,  6'd0 },  // vertical, x tie picks low y
    '{1'b0, 6'd0,  6'd0,  6'd63, 6'd63, 6'd0,  6'd0 },  // diagonal, equal extents
    '{1'b0, 6'd63, 6'd0,  6'd0,  6'd63, 6'd0,  6'd0 },  // anti-diagonal, y falls
    '{1'b0, 6'd63, 6'd63, 6'd0,  6'd0,  6'd0,  6'd0 },
    '{1'b0, 6'd0,  6'd0,  6'd63, 6'd1,  6'd0,  6'd0 },  // shallow, minor of one
    '{1'b0, 6'd0,  6'd0,  6'd1,  6'd63, 6'd0,  6'd0 },  // steep, minor of one
    '{1'b0, 6'd5,  6'd60, 6'd50, 6'd3,  6'd0,  6'd0 },  // steep, y falls
    '{1'b0, 6'd20, 6'd50, 6'd30, 6'd2,  6'd0,  6'd0 },  // steep, y falls
    '{1'b0, 6'd30, 6'd50, 6'd20, 6'd2,  6'd0,  6'd0 },  // steep, y rises
    '{1'b0, 6'd0,  6'd63, 6'd63, 6'd62, 6'd0,  6'd0 },
    '{1'b0, 6'd10, 6'd10, 6'd11, 6'd10, 6'd0,  6'd0 },  // two-pixel horizontal
    '{1'b0, 6'd10, 6'd10, 6'd10, 6'd9,  6'd0,  6'd0 },  // two-pixel vertical
    '{1'b0, 6'd0,  6'd0,  6'd2,  6'd1,  6'd0,  6'd0 },  // error exactly at threshold
    '{1'b0, 6'd0,  6'd0,  6'd1,  6'd2,  6'd0,  6'd0 }
  };

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  coord_t in_end_a_x;
  coord_t in_end_a_y;
  coord_t in_end_b_x;
  coord_t in_end_b_y;
  logic   out_valid;
  logic   out_ready;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last_pixel;

  pixel_t expected_pixels [$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  bit     sender_idles   = 1'b1;
  bit     receiver_idles = 1'b1;
  bit     long_hold_req  = 1'b0;

  line_segment_rasterizer i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_end_a_x    (in_end_a_x),
    .in_end_a_y    (in_end_a_y),
    .in_end_b_x    (in_end_b_x),
    .in_end_b_y    (in_end_b_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Saturate a coordinate to the tile
  function automatic coord_t clamp_to_tile(coord_t v);
    if (int'(v) > TILE - 1) return coord_t'(TILE - 1);
    return v;
  endfunction

  // Offset a coordinate, saturating at the tile edges
  function automatic coord_t offset_coord(coord_t c, int off);
    int v;
    v = int'(c) + off;
    if (v < 0) v = 0;
    if (v > TILE - 1) v = TILE - 1;
    return coord_t'(v);
  endfunction

  // Walk the segment along its major axis and queue every pixel it covers
  function automatic void trace_segment(coord_t ax_in, coord_t ay_in,
                                        coord_t bx_in, coord_t by_in);
    coord_t ax, ay, bx, by, sx, sy, ex, ey, cur_x, cur_y;
    int     dx, dy, major, minor, err, left;
    logic   steep, descending;
    pixel_t pix;
    ax = clamp_to_tile(ax_in);
    ay = clamp_to_tile(ay_in);
    bx = clamp_to_tile(bx_in);
    by = clamp_to_tile(by_in);
    // Start from the lower x, or the lower y on an x tie
    if (ax < bx || (ax == bx && ay < by)) begin
      sx = ax; sy = ay; ex = bx; ey = by;
    end else begin
      sx = bx; sy = by; ex = ax; ey = ay;
    end
    dx         = int'(ex) - int'(sx);
    descending = (ey < sy);
    dy         = descending ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
    // Equal extents count as steep
    steep = !(dx > dy);
    major = steep ? dy : dx;
    minor = steep ? dx : dy;
    cur_x = sx;
    cur_y = sy;
    err   = 0;
    for (left = major; left >= 0; left--) begin
      pix.x    = cur_x;
      pix.y    = cur_y;
      pix.last = (left == 0);
      expected_pixels.push_back(pix);
      // Move the minor axis once twice the error passes the major extent
      err = err + minor;
      if (2 * err > major) begin
        err = err - major;
        if (steep) cur_x = cur_x + 1'b1;
        else       cur_y = descending ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      if (steep) cur_y = descending ? cur_y - 1'b1 : cur_y + 1'b1;
      else       cur_x = cur_x + 1'b1;
    end
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    if (sender_idles && $urandom_range(0, 5) == 0) return $urandom_range(1, 12);
    return 0;
  endfunction

  // Offer one segment beat and hold it until taken; queue its pixels then
  task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                              logic typed, coord_t px, coord_t py, int gap);
    logic   took;
    pixel_t pix;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_end_a_x <= ax;
    in_end_a_y <= ay;
    in_end_b_x <= bx;
    in_end_b_y <= by;
    do begin
      @(negedge clk);
      took = in_ready;
      if (took) begin
        if (typed) begin
          pix.x    = px;
          pix.y    = py;
          pix.last = 1'b1;
          expected_pixels.push_back(pix);
        end else begin
          trace_segment(ax, ay, bx, by);
        end
      end
      @(posedge clk);
    end while (!took);
  endtask

  // Draw one random segment: mostly free endpoints, some short, flat or diagonal
  task automatic send_random_segment(int gap);
    coord_t ax, ay, bx, by;
    int     shape, len;
    ax    = coord_t'($urandom_range(0, 63));
    ay    = coord_t'($urandom_range(0, 63));
    bx    = coord_t'($urandom_range(0, 63));
    by    = coord_t'($urandom_range(0, 63));
    shape = $urandom_range(0, 9);
    len   = $urandom_range(0, 63);
    case (shape)
      5, 6: begin
        bx = offset_coord(ax, $urandom_range(0, 6) - 3);
        by = offset_coord(ay, $urandom_range(0, 6) - 3);
      end
      7: by = ay;
      8: bx = ax;
      9: begin
        bx = offset_coord(ax, $urandom_range(0, 1) ? len : -len);
        by = offset_coord(ay, $urandom_range(0, 1) ? len : -len);
      end
      default: ;
    endcase
    send_segment(ax, ay, bx, by, 1'b0, '0, '0, gap);
  endtask

  task automatic wait_drained();
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Drive out_ready: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_STALL;
      end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each pixel beat against the oldest expectation
  initial begin
    pixel_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          flag_mismatch("unexpected pixel beat, x", int'(out_pixel_x), -1);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_x !== want.x)
            flag_mismatch("pixel_x", int'(out_pixel_x), int'(want.x));
          if (out_pixel_y !== want.y)
            flag_mismatch("pixel_y", int'(out_pixel_y), int'(want.y));
          if (out_last_pixel !== want.last)
            flag_mismatch("last_pixel", int'(out_last_pixel), int'(want.last));
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    seg_row_t row;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_end_a_x <= '0;
    in_end_a_y <= '0;
    in_end_b_x <= '0;
    in_end_b_y <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      send_segment(row.ax, row.ay, row.bx, row.by, row.typed, row.px, row.py,
                   pick_gap());
    end

    // Random segments with idling on both sides
    for (int i = 0; i < N_PHASE_A; i++) send_random_segment(pick_gap());

    // Hold the receiver off and keep offering so the block backs up
    long_hold_req = 1'b1;
    for (int i = 0; i < N_BACKUP; i++) send_random_segment(0);

    // Pause the sender until every pixel is out
    in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < N_PHASE_B; i++) send_random_segment(pick_gap());

    // Finish at full rate with no idling
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    for (int i = 0; i < N_FULL_RATE; i++) send_random_segment(0);
    in_valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/lsr_pkg.sv
sv/lsr_ctrl.sv
sv/lsr_dpath.sv
sv/line_segment_rasterizer.sv
tb/line_segment_rasterizer_tb.sv
